>>> hw/rtl/ipc_pkg.sv
package ipc_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned FlagW = 2;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [FlagW-1:0] FLAG_NONE = 2'd0;
	localparam logic [FlagW-1:0] FLAG_MAX  = 2'd1;
	localparam logic [FlagW-1:0] FLAG_MIN  = 2'd2;

	localparam logic [IdxW-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [IdxW-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [IdxW-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [IdxW-1:0] REG_OUT_MAX  = 3'd3;
	localparam logic [IdxW-1:0] REG_OUT_MIN  = 3'd4;
	localparam logic [IdxW-1:0] REG_STEP_MAX = 3'd5;
	localparam logic [IdxW-1:0] REG_STEP_MIN = 3'd6;
	localparam logic [IdxW-1:0] REG_REVERSE  = 3'd7;

	localparam logic signed [DataW-1:0] STEP_MAX_RST = 32'sh7fff_ffff;
	localparam logic signed [DataW-1:0] STEP_MIN_RST = 32'sh8000_0000;

	typedef struct packed {
		logic                     kind;
		logic signed [DataW-1:0]  target;
		logic signed [DataW-1:0]  sample;
	} req_t;

	typedef struct packed {
		logic signed [DataW-1:0]  drive;
		logic [FlagW-1:0]         limit_flag;
	} rsp_t;

endpackage

>>> hw/rtl/incremental_pid_clamped.sv
// An accepted request is registered in req_s1, then in the stage-2 registers, then in rsp_q, which drives the result.
// Throughput: one request per cycle while results are taken; two more fit behind a waiting one.
// Stage 1 holds the three 32x32 gain multipliers and the error history; stage 2 holds
// the increment clamp, the output accumulator loop through output_q and the output clamp.
// Reset (arst_n low, asynchronous) clears the output, the error history and all
// valid flags, and loads the registers with their reset values.
module incremental_pid_clamped
	import ipc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_idx,
	input  logic [DataW-1:0] cfg_data
);

	logic signed [DataW-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [DataW-1:0] out_max_q, out_min_q, step_max_q, step_min_q;
	logic                    reverse_q;

	logic signed [DataW-1:0] output_q, err1_q, err2_q;

	logic                    valid_s1, valid_s2, rsp_valid_q;
	req_t                    req_s1;
	logic                    kind_s2;
	logic [DataW-1:0]        prod_p_s2, prod_i_s2, prod_d_s2;
	rsp_t                    rsp_q;

	logic                    out_en, en2, en1;

	logic [DataW-1:0]        err, diff1, diff2, prod_p, prod_i, prod_d;

	logic signed [DataW-1:0] raw, delta;
	logic signed [DataW+1:0] sum;
	rsp_t                    rsp_d;

	assign out_en    = !rsp_valid_q || rsp_ready;
	assign en2       = !valid_s2 || out_en;
	assign en1       = !valid_s1 || en2;
	assign req_ready = en1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			out_max_q  <= '0;
			out_min_q  <= '0;
			step_max_q <= STEP_MAX_RST;
			step_min_q <= STEP_MIN_RST;
			reverse_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GAIN_P:   gain_p_q   <= cfg_data;
				REG_GAIN_I:   gain_i_q   <= cfg_data;
				REG_GAIN_D:   gain_d_q   <= cfg_data;
				REG_OUT_MAX:  out_max_q  <= cfg_data;
				REG_OUT_MIN:  out_min_q  <= cfg_data;
				REG_STEP_MAX: step_max_q <= cfg_data;
				REG_STEP_MIN: step_min_q <= cfg_data;
				REG_REVERSE:  reverse_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: error terms against the history, and the three gain products.
	always_comb begin
		err    = req_s1.target - req_s1.sample;
		diff1  = err - err1_q;
		diff2  = err - {err1_q[DataW-2:0], 1'b0} + err2_q;
		prod_p = gain_p_q * diff1;
		prod_i = gain_i_q * err;
		prod_d = gain_d_q * diff2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			err1_q   <= '0;
			err2_q   <= '0;
		end else begin
			if (en1) begin
				valid_s1 <= req_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && en2) begin
				if (req_s1.kind == KIND_CLEAR) begin
					err1_q <= '0;
					err2_q <= '0;
				end else begin
					err1_q <= err;
					err2_q <= err1_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			req_s1 <= req;
		end
		if (en2 && valid_s1) begin
			kind_s2   <= req_s1.kind;
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
			prod_d_s2 <= prod_d;
		end
	end

	// Stage 2: increment clamp, accumulate, output clamp with the upper bound first.
	always_comb begin
		raw = prod_p_s2 + prod_i_s2 + prod_d_s2;
		if (raw > step_max_q) begin
			delta = step_max_q;
		end else if (raw < step_min_q) begin
			delta = step_min_q;
		end else begin
			delta = raw;
		end
		if (reverse_q) begin
			sum = {{2{output_q[DataW-1]}}, output_q} - {{2{delta[DataW-1]}}, delta};
		end else begin
			sum = {{2{output_q[DataW-1]}}, output_q} + {{2{delta[DataW-1]}}, delta};
		end
		if (kind_s2 == KIND_CLEAR) begin
			rsp_d.drive      = output_q;
			rsp_d.limit_flag = FLAG_NONE;
		end else if (sum >= $signed({{2{out_max_q[DataW-1]}}, out_max_q})) begin
			rsp_d.drive      = out_max_q;
			rsp_d.limit_flag = FLAG_MAX;
		end else if (sum <= $signed({{2{out_min_q[DataW-1]}}, out_min_q})) begin
			rsp_d.drive      = out_min_q;
			rsp_d.limit_flag = FLAG_MIN;
		end else begin
			rsp_d.drive      = sum[DataW-1:0];
			rsp_d.limit_flag = FLAG_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			output_q    <= '0;
		end else begin
			if (out_en) begin
				rsp_valid_q <= valid_s2;
			end
			if (out_en && valid_s2) begin
				output_q <= rsp_d.drive;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			rsp_q <= rsp_d;
		end
	end

	// The result register and the held output are loaded together.
	a_drive_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_en && valid_s2) |=> (rsp.drive == output_q))
		else $error("result drive differs from held output");

	// A clear request empties the error history as it leaves stage 1.
	a_clear_history: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && req_s1.kind == KIND_CLEAR) |=> (err1_q == '0 && err2_q == '0))
		else $error("error history not cleared");

	// A clear request keeps the output and reports no limit.
	a_clear_keeps_output: assert property (@(posedge clk) disable iff (!arst_n)
		(out_en && valid_s2 && kind_s2 == KIND_CLEAR)
		|=> (rsp.limit_flag == FLAG_NONE && $stable(output_q)))
		else $error("clear request changed the output");

	// Backpressure reaches the request side only when stage 1 is occupied.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1)
		else $error("request side stalled with an empty stage");

endmodule
